### hdl/mpbm_pkg.sv
// Shared types and constants for the multi-pattern byte matcher.
// No dependencies; imported by every module of the block.
package mpbm_pkg;

  localparam int BYTE_W       = 8;
  localparam int PAT_REG_W    = 64;
  localparam int NUM_PAT_REGS = 6;
  localparam int LEN_W        = 4;
  localparam int LENS_W       = NUM_PAT_REGS * LEN_W;
  localparam int AGE_W        = 4;
  localparam int PAT_IDX_W    = 3;
  localparam int CFG_IDX_W    = 3;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // configuration register map
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LAST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS       = 3'd6;

  localparam logic [PAT_REG_W-1:0] PATTERN_RESET [NUM_PAT_REGS] = '{
    64'h0000_0000_0041_4141, 64'h0000_0000_0042_4242, 64'h0000_0000_0043_4343,
    64'h0000_0000_0044_4444, 64'h0000_0000_0043_4443, 64'h0000_0000_0044_4241
  };
  localparam logic [LENS_W-1:0] LENGTHS_RESET = 24'h33_3333;

  // one comparison lane's verdict for the current byte
  typedef struct packed {
    logic             hit;
    logic [AGE_W-1:0] age;
  } lane_hit_t;

  // running best match of the current message
  typedef struct packed {
    logic                 found;
    logic [PAT_IDX_W-1:0] pat;
    logic [AGE_W-1:0]     age;
  } best_t;

endpackage

### hdl/multi_pattern_byte_matcher_core.sv
// Top level of the multi-pattern byte matcher: input register, parallel
// comparison lanes, best-match fold and result register. Depends on mpbm_pkg,
// mpbm_pattern_cmp and mpbm_best_sel.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   in_     | into core | in_valid / in_ready  | in_data_byte, in_has_byte, in_is_last
//   out_    | from core | out_valid / out_ready| out_is_spam, out_pattern_index
//   cfg_    | into core | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each transaction is held in the input register, where the lanes and the
// fold work on it combinationally; one transaction per cycle is sustained
// while no message end stalls. The critical path is one lane's byte compares
// plus the best-match fold over the lanes.
// A transaction ending the message puts its result in the output register as
// it leaves the input register; it stalls in the input register only while that
// result register is still full and not being taken. cfg_ready is always high.
// Reset (rst_n low, synchronous) loads the default patterns and lengths and
// clears the message state and both valid flags.
module multi_pattern_byte_matcher_core #(
  parameter int NUM_PATTERNS    = 6,
  parameter int MAX_PATTERN_LEN = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mpbm_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                               in_has_byte,
  input  logic                               in_is_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_is_spam,
  output logic [mpbm_pkg::PAT_IDX_W-1:0]     out_pattern_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpbm_pkg::PAT_REG_W-1:0]     cfg_data
);
  import mpbm_pkg::*;

  // patterns beyond the register file are disabled, so they get no lane
  localparam int NUM_LANES = (NUM_PATTERNS < NUM_PAT_REGS) ? NUM_PATTERNS : NUM_PAT_REGS;
  localparam int HIST_W    = BYTE_W * (MAX_PATTERN_LEN - 1);
  localparam int SEEN_W    = $clog2(MAX_PATTERN_LEN);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_PATTERN_LEN - 1);

  // configuration registers
  logic [PAT_REG_W-1:0] pattern_r [NUM_PAT_REGS];
  logic [LENS_W-1:0]    lengths_r;

  // input register
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_has_r;
  logic              in_last_r;

  // message state
  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  best_t             best_r, best_nxt, best_upd;

  // result register
  logic                 out_valid_r;
  logic                 out_spam_r;
  logic [PAT_IDX_W-1:0] out_idx_r;

  logic      advance;
  lane_hit_t lane_hits [NUM_LANES];
  logic [BYTE_W*MAX_PATTERN_LEN-1:0] window;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAT_REGS; i++) begin
        pattern_r[i] <= PATTERN_RESET[i];
      end
      lengths_r <= LENGTHS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        [CFG_PATTERN_FIRST:CFG_PATTERN_LAST]: pattern_r[cfg_index] <= cfg_data;
        CFG_LENGTHS:                          lengths_r <= cfg_data[LENS_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ----------------------------------------------------------- input stage
  // A transaction that ends the message needs room in the result register.
  assign advance  = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_has_r  <= in_has_byte;
      in_last_r <= in_is_last;
    end
  end

  // ------------------------------------------------------ comparison lanes
  // newest byte at the bottom, older bytes above it
  assign window = {hist_r, in_byte_r};

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mpbm_pattern_cmp #(
      .MAX_LEN (MAX_PATTERN_LEN),
      .SEEN_W  (SEEN_W)
    ) u_cmp (
      .pattern (pattern_r[g]),
      .len_raw (lengths_r[LEN_W*g +: LEN_W]),
      .window  (window),
      .seen    (seen_r),
      .hit_o   (lane_hits[g])
    );
  end

  mpbm_best_sel #(
    .NUM_LANES (NUM_LANES)
  ) u_sel (
    .lanes_i (lane_hits),
    .best_i  (best_r),
    .best_o  (best_upd)
  );

  // ------------------------------------------------------- message state
  always_comb begin
    hist_nxt = hist_r;
    seen_nxt = seen_r;
    best_nxt = best_r;
    if (in_has_r) begin
      hist_nxt = HIST_W'({hist_r, in_byte_r});
      if (seen_r != SEEN_MAX) begin
        seen_nxt = seen_r + SEEN_W'(1);
      end
      best_nxt = best_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      seen_r <= '0;
      best_r <= '0;
    end else if (advance) begin
      if (in_last_r) begin
        hist_r <= '0;
        seen_r <= '0;
        best_r <= '0;
      end else begin
        hist_r <= hist_nxt;
        seen_r <= seen_nxt;
        best_r <= best_nxt;
      end
    end
  end

  // ------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_spam_r <= best_nxt.found;
      out_idx_r  <= best_nxt.found ? best_nxt.pat : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_spam       = out_spam_r;
  assign out_pattern_index = out_idx_r;

  // ------------------------------------------------------------ assertions
  a_idx_zero_when_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_spam_r || out_idx_r == '0))
    else $error("pattern index set on a clean message");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> (!best_r.found && seen_r == '0 && hist_r == '0))
    else $error("message state not cleared after end of message");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    best_r.found |-> (best_r.pat < PAT_IDX_W'(NUM_LANES)))
    else $error("best pattern index outside the lanes");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(advance && in_last_r))
    else $error("result register overwritten while full");

endmodule

### hdl/mpbm_pattern_cmp.sv
// One comparison lane: checks a single pattern against the byte window.
// Depends on mpbm_pkg.
module mpbm_pattern_cmp #(
  parameter int MAX_LEN = 8,
  parameter int SEEN_W  = 3
) (
  input  logic [mpbm_pkg::PAT_REG_W-1:0]    pattern,
  input  logic [mpbm_pkg::LEN_W-1:0]        len_raw,
  input  logic [mpbm_pkg::BYTE_W*MAX_LEN-1:0] window,
  input  logic [SEEN_W-1:0]                 seen,
  output mpbm_pkg::lane_hit_t               hit_o
);
  import mpbm_pkg::*;

  logic [LEN_W-1:0] len_c;
  logic             all_eq;
  logic             eq_sel;

  // window byte at age a sits at bits 8a+7:8a; pattern byte m must meet age len-1-m
  always_comb begin
    len_c  = (len_raw > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_raw;
    eq_sel = 1'b0;
    all_eq = 1'b1;
    for (int l = 1; l <= MAX_LEN; l++) begin
      all_eq = 1'b1;
      for (int m = 0; m < l; m++) begin
        all_eq = all_eq &
                 (pattern[BYTE_W*m +: BYTE_W] == window[BYTE_W*(l-1-m) +: BYTE_W]);
      end
      if (len_c == LEN_W'(l)) begin
        eq_sel = all_eq;
      end
    end
    hit_o.hit = (len_c != '0) && ((len_c - LEN_W'(1)) <= LEN_W'(seen)) && eq_sel;
    hit_o.age = AGE_W'(len_c - LEN_W'(1));
  end

endmodule

### hdl/mpbm_best_sel.sv
// Folds the lane verdicts into the running best match: earliest start wins,
// then lowest pattern index. Depends on mpbm_pkg.
module mpbm_best_sel #(
  parameter int NUM_LANES = 6
) (
  input  mpbm_pkg::lane_hit_t lanes_i [NUM_LANES],
  input  mpbm_pkg::best_t     best_i,
  output mpbm_pkg::best_t     best_o
);
  import mpbm_pkg::*;

  best_t cur;

  always_comb begin
    cur = best_i;
    // the old best start moves one byte further back
    if (cur.found && cur.age != AGE_MAX) begin
      cur.age = cur.age + AGE_W'(1);
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lanes_i[i].hit &&
          (!cur.found || lanes_i[i].age > cur.age ||
           (lanes_i[i].age == cur.age && PAT_IDX_W'(i) < cur.pat))) begin
        cur.found = 1'b1;
        cur.pat   = PAT_IDX_W'(i);
        cur.age   = lanes_i[i].age;
      end
    end
    best_o = cur;
  end

endmodule
